// ===== rtl/core/ssat_pkg.sv =====
`timescale 1ns / 1ps
package ssat_pkg;

	// default build parameters
	localparam int CHANNELS_DEF        = 2;
	localparam int SAMPLE_BITS_DEF     = 24;
	localparam int SINE_TABLE_BITS_DEF = 10;

	// shared multiplier and datapath widths
	localparam int MUL_W   = 34;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int FILT_W  = 32;
	localparam int ACC_W   = 40;
	localparam int PHASE_W = 24;
	localparam int COEF_W  = 21;
	localparam int CFG_W   = 63;
	localparam int IDX_W   = 3;

	localparam logic [14:0] TANH_MAX = 15'd32746;

	typedef enum logic [IDX_W-1:0] {
		REG_BAND_COEFFS  = 3'd0,
		REG_SUB_COEFFS   = 3'd1,
		REG_PHASE_STEP   = 3'd2,
		REG_SUB_GAIN     = 3'd3,
		REG_DRIVE_GAIN   = 3'd4,
		REG_BLEND_AMOUNT = 3'd5,
		REG_TRIM_GAIN    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] band_coeffs;
		logic [CFG_W-1:0] sub_coeffs;
		logic [19:0]      phase_step;
		logic [14:0]      sub_gain;
		logic [15:0]      drive_gain;
		logic [15:0]      blend_amount;
		logic [14:0]      trim_gain;
	} cfg_t;

	// tanh(k/8) in q1.15
	function automatic logic [14:0] tanh_tab(input logic [5:0] k);
		logic [14:0] v;
		case (k)
			6'd0:  v = 15'd0;
			6'd1:  v = 15'd4075;
			6'd2:  v = 15'd8026;
			6'd3:  v = 15'd11743;
			6'd4:  v = 15'd15143;
			6'd5:  v = 15'd18173;
			6'd6:  v = 15'd20813;
			6'd7:  v = 15'd23066;
			6'd8:  v = 15'd24956;
			6'd9:  v = 15'd26519;
			6'd10: v = 15'd27797;
			6'd11: v = 15'd28830;
			6'd12: v = 15'd29660;
			6'd13: v = 15'd30322;
			6'd14: v = 15'd30847;
			6'd15: v = 15'd31262;
			6'd16: v = 15'd31589;
			6'd17: v = 15'd31846;
			6'd18: v = 15'd32048;
			6'd19: v = 15'd32206;
			6'd20: v = 15'd32329;
			6'd21: v = 15'd32426;
			6'd22: v = 15'd32501;
			6'd23: v = 15'd32560;
			6'd24: v = 15'd32606;
			6'd25: v = 15'd32642;
			6'd26: v = 15'd32670;
			6'd27: v = 15'd32691;
			6'd28: v = 15'd32708;
			6'd29: v = 15'd32721;
			6'd30: v = 15'd32732;
			6'd31: v = 15'd32740;
			default: v = TANH_MAX;
		endcase
		return v;
	endfunction

	// clamp a wide signed value to signed 32 bits
	function automatic logic signed [FILT_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [FILT_W-1:0] r;
		if (v[PROD_W-1] && !(&v[PROD_W-1:FILT_W-1]))
			r = {1'b1, {(FILT_W-1){1'b0}}};
		else if (!v[PROD_W-1] && (|v[PROD_W-1:FILT_W-1]))
			r = {1'b0, {(FILT_W-1){1'b1}}};
		else
			r = v[FILT_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/core/ssat_mul.sv =====
`timescale 1ns / 1ps
module ssat_mul
	import ssat_pkg::*;
(
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] p_q
);

	// product lands in the cycle after the operands
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ===== rtl/core/ssat_regs.sv =====
`timescale 1ns / 1ps
module ssat_regs
	import ssat_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data,
	output cfg_t             cfg_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_coeffs  <= '0;
			cfg_q.sub_coeffs   <= '0;
			cfg_q.phase_step   <= 20'd30436;
			cfg_q.sub_gain     <= 15'd18350;
			cfg_q.drive_gain   <= 16'd27853;
			cfg_q.blend_amount <= 16'd21299;
			cfg_q.trim_gain    <= 15'd8192;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_BAND_COEFFS:  cfg_q.band_coeffs  <= wr_data;
				REG_SUB_COEFFS:   cfg_q.sub_coeffs   <= wr_data;
				REG_PHASE_STEP:   cfg_q.phase_step   <= wr_data[19:0];
				REG_SUB_GAIN:     cfg_q.sub_gain     <= wr_data[14:0];
				REG_DRIVE_GAIN:   cfg_q.drive_gain   <= wr_data[15:0];
				REG_BLEND_AMOUNT: cfg_q.blend_amount <= wr_data[15:0];
				REG_TRIM_GAIN:    cfg_q.trim_gain    <= wr_data[14:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/subharmonic_saturator.sv =====
`timescale 1ns / 1ps
// subharmonic bass synthesizer with tanh saturation
// sample channel: sample_valid/sample_ready carry one audio sample and its
// channel index per beat; result channel: result_valid/result_ready carry the
// processed sample and the echoed channel index per beat.
// configuration: cfg_valid/cfg_ready write register cfg_index with cfg_data;
// cfg_ready is always high, writes are meant to happen while the block is idle.
// result_valid rises after a sequencer has stepped one shared 34x34
// multiplier through the sine polynomial, both biquads, the gains, the tanh
// interpolation and the trim.
// a new sample is taken only after the last one is through; sample_ready is
// high only in the idle state. a channel index at or above CHANNELS skips the
// math and goes straight to the final state with a zero result.
// the result sits in an output register, so a new sample is taken while a
// finished result still waits; a stalled receiver only holds the next result
// back at the last step until the output register frees.
// reset clears the filter state, the oscillator phase, the registers to
// their reset values and drops result_valid.
module subharmonic_saturator
	import ssat_pkg::*;
#(
	parameter int CHANNELS        = CHANNELS_DEF,
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          channel,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic                          channel_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [IDX_W-1:0]              cfg_index,
	input  logic [CFG_W-1:0]              cfg_data
);

	localparam int FRAC      = SAMPLE_BITS - 1;
	localparam int SEG_SHIFT = FRAC - 3;
	localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STB       = SINE_TABLE_BITS;

	localparam logic signed [PROD_W-1:0] HALF13  = PROD_W'(1) << 12;
	localparam logic signed [PROD_W-1:0] HALF15  = PROD_W'(1) << 14;
	localparam logic signed [PROD_W-1:0] HALF18  = PROD_W'(1) << 17;
	localparam logic signed [PROD_W-1:0] HALFSEG = PROD_W'(1) << (SEG_SHIFT - 1);
	localparam logic signed [PROD_W-1:0] FULL_HI = (PROD_W'(1) << FRAC) - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] FULL_LO = -(PROD_W'(1) << FRAC);

	// sequencer, one hot
	typedef enum logic [28:0] {
		ST_IDLE  = 29'd1 << 0,
		ST_SZ    = 29'd1 << 1,
		ST_S2    = 29'd1 << 2,
		ST_S3    = 29'd1 << 3,
		ST_S4    = 29'd1 << 4,
		ST_S5    = 29'd1 << 5,
		ST_S6    = 29'd1 << 6,
		ST_S7    = 29'd1 << 7,
		ST_BX    = 29'd1 << 8,
		ST_BY    = 29'd1 << 9,
		ST_BA1   = 29'd1 << 10,
		ST_BA2   = 29'd1 << 11,
		ST_BS2   = 29'd1 << 12,
		ST_RECT  = 29'd1 << 13,
		ST_MSYN  = 29'd1 << 14,
		ST_GSYN  = 29'd1 << 15,
		ST_MGAIN = 29'd1 << 16,
		ST_GSUM  = 29'd1 << 17,
		ST_MDRV  = 29'd1 << 18,
		ST_GDRV  = 29'd1 << 19,
		ST_TSEG  = 29'd1 << 20,
		ST_MTANH = 29'd1 << 21,
		ST_GTANH = 29'd1 << 22,
		ST_DIFF  = 29'd1 << 23,
		ST_MBL   = 29'd1 << 24,
		ST_GMIX  = 29'd1 << 25,
		ST_MTRIM = 29'd1 << 26,
		ST_GOUT  = 29'd1 << 27,
		ST_FIN   = 29'd1 << 28
	} state_t;

	state_t state_q;

	cfg_t cfg_q;

	// sample context
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          ch_q;
	logic                          adv_q;
	logic                          fsel_q;
	logic [PHASE_W-1:0]            phase_q;

	// filter state per filter and channel
	logic signed [FILT_W-1:0] m0_q [2][CHANNELS];
	logic signed [FILT_W-1:0] m1_q [2][CHANNELS];

	// working registers
	logic signed [PROD_W-1:0]      bx_q;
	logic signed [FILT_W-1:0]      y_q;
	logic signed [FILT_W-1:0]      low_q;
	logic [FILT_W-2:0]             rect_q;
	logic [16:0]                   z2_q;
	logic [16:0]                   t_q;
	logic signed [15:0]            sine_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          neg_q;
	logic                          big_q;
	logic [14:0]                   base_q;
	logic [11:0]                   d_q;
	logic [SEG_SHIFT-1:0]          frac_q;
	logic signed [SAMPLE_BITS-1:0] res_q;

	// shared multiplier
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] p_q;

	ssat_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	ssat_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg_q    (cfg_q)
	);

	assign cfg_ready    = 1'b1;
	assign sample_ready = (state_q == ST_IDLE);

	logic [CH_W-1:0] chi;
	logic            in_ok;
	assign chi   = CH_W'(ch_q);
	assign in_ok = (4'(channel) < 4'(CHANNELS));

	// current filter coefficients
	logic [CFG_W-1:0]         coefs;
	logic signed [COEF_W-1:0] b0;
	logic signed [COEF_W-1:0] a1;
	logic signed [COEF_W-1:0] a2;
	assign coefs = fsel_q ? cfg_q.sub_coeffs : cfg_q.band_coeffs;
	assign b0    = coefs[COEF_W-1:0];
	assign a1    = coefs[2*COEF_W-1:COEF_W];
	assign a2    = coefs[3*COEF_W-1:2*COEF_W];

	// sine phase, quarter wave folding
	logic [STB-1:0] idx;
	logic [1:0]     quad;
	logic [16:0]    zb;
	logic [16:0]    z;
	assign idx  = phase_q[PHASE_W-1 -: STB];
	assign quad = idx[STB-1 -: 2];
	assign zb   = 17'(idx[STB-3:0]) << (18 - STB);
	assign z    = quad[0] ? (17'd65536 - zb) : zb;

	logic [15:0] blend;
	assign blend = (cfg_q.blend_amount > 16'd32768) ? 16'd32768 : cfg_q.blend_amount;

	// operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SZ: begin
				mul_a = MUL_W'(signed'({1'b0, z}));
				mul_b = MUL_W'(signed'({1'b0, z}));
			end
			ST_S2: begin
				mul_a = MUL_W'(signed'({1'b0, 13'd4640}));
				mul_b = MUL_W'(signed'({1'b0, p_q[32:16]}));
			end
			ST_S4: begin
				mul_a = MUL_W'(signed'({1'b0, t_q}));
				mul_b = MUL_W'(signed'({1'b0, z2_q}));
			end
			ST_S6: begin
				mul_a = MUL_W'(signed'({1'b0, t_q}));
				mul_b = MUL_W'(signed'({1'b0, z}));
			end
			ST_BX: begin
				mul_a = MUL_W'(b0);
				mul_b = MUL_W'(x_q);
			end
			ST_BA1: begin
				mul_a = MUL_W'(a1);
				mul_b = MUL_W'(y_q);
			end
			ST_BA2: begin
				mul_a = MUL_W'(a2);
				mul_b = MUL_W'(y_q);
			end
			ST_MSYN: begin
				mul_a = MUL_W'(sine_q);
				mul_b = MUL_W'(signed'({1'b0, rect_q}));
			end
			ST_MGAIN: begin
				mul_a = MUL_W'(acc_q);
				mul_b = MUL_W'(signed'({1'b0, cfg_q.sub_gain}));
			end
			ST_MDRV: begin
				mul_a = MUL_W'(acc_q);
				mul_b = MUL_W'(signed'({1'b0, cfg_q.drive_gain}));
			end
			ST_MTANH: begin
				mul_a = MUL_W'(signed'({1'b0, d_q}));
				mul_b = MUL_W'(signed'({1'b0, frac_q}));
			end
			ST_MBL: begin
				mul_a = MUL_W'(acc_q);
				mul_b = MUL_W'(signed'({1'b0, blend}));
			end
			ST_MTRIM: begin
				mul_a = MUL_W'(acc_q);
				mul_b = MUL_W'(signed'({1'b0, cfg_q.trim_gain}));
			end
			default: ;
		endcase
	end

	// datapath arithmetic on the registered product
	logic signed [PROD_W-1:0] y_sum;
	logic signed [PROD_W-1:0] s1_sum;
	logic signed [PROD_W-1:0] s2_sum;
	logic [16:0]              s_raw;
	logic [14:0]              s_clip;
	logic [ACC_W-1:0]         mag;
	logic [4:0]               seg;
	logic [14:0]              tab_lo;
	logic [14:0]              tab_hi;
	logic [15:0]              tanh_y;
	logic signed [ACC_W-1:0]  forged;
	logic signed [PROD_W-1:0] out_r;
	logic signed [SAMPLE_BITS-1:0] out_sat;

	always_comb begin
		y_sum  = (p_q + (PROD_W'(m0_q[fsel_q][chi]) <<< 18) + HALF18) >>> 18;
		s1_sum = (((bx_q <<< 1) - p_q + HALF18) >>> 18) + PROD_W'(m1_q[fsel_q][chi]);
		s2_sum = (bx_q - p_q + HALF18) >>> 18;

		s_raw  = p_q[33:17];
		s_clip = (s_raw > 17'd32767) ? 15'd32767 : s_raw[14:0];

		mag    = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
		seg    = mag[SEG_SHIFT+4:SEG_SHIFT];
		tab_lo = tanh_tab({1'b0, seg});
		tab_hi = tanh_tab(6'({1'b0, seg}) + 6'd1);

		tanh_y = big_q ? {1'b0, TANH_MAX}
			: 16'(base_q) + 16'((p_q + HALFSEG) >>> SEG_SHIFT);
		forged = ACC_W'(tanh_y) <<< (FRAC - 15);

		out_r = (p_q + HALF13) >>> 13;
		if (out_r > FULL_HI)
			out_sat = SAMPLE_BITS'(FULL_HI);
		else if (out_r < FULL_LO)
			out_sat = SAMPLE_BITS'(FULL_LO);
		else
			out_sat = SAMPLE_BITS'(out_r);
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fsel_q       <= 1'b0;
			adv_q        <= 1'b0;
			phase_q      <= '0;
			result_valid <= 1'b0;
			for (int f = 0; f < 2; f++) begin
				for (int c = 0; c < CHANNELS; c++) begin
					m0_q[f][c] <= '0;
					m1_q[f][c] <= '0;
				end
			end
		end else begin
			if (result_valid && result_ready)
				result_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						fsel_q  <= 1'b0;
						adv_q   <= in_ok && (4'(channel) == 4'(CHANNELS - 1));
						state_q <= in_ok ? ST_SZ : ST_FIN;
					end
				end
				ST_SZ:    state_q <= ST_S2;
				ST_S2:    state_q <= ST_S3;
				ST_S3:    state_q <= ST_S4;
				ST_S4:    state_q <= ST_S5;
				ST_S5:    state_q <= ST_S6;
				ST_S6:    state_q <= ST_S7;
				ST_S7:    state_q <= ST_BX;
				ST_BX:    state_q <= ST_BY;
				ST_BY:    state_q <= ST_BA1;
				ST_BA1:   state_q <= ST_BA2;
				ST_BA2: begin
					m0_q[fsel_q][chi] <= sat32(s1_sum);
					state_q <= ST_BS2;
				end
				ST_BS2: begin
					m1_q[fsel_q][chi] <= sat32(s2_sum);
					// after the band pass, rerun the same steps for the sub filter; after the sub filter, go on
					fsel_q  <= 1'b1;
					state_q <= fsel_q ? ST_RECT : ST_BX;
				end
				ST_RECT:  state_q <= ST_MSYN;
				ST_MSYN:  state_q <= ST_GSYN;
				ST_GSYN:  state_q <= ST_MGAIN;
				ST_MGAIN: state_q <= ST_GSUM;
				ST_GSUM:  state_q <= ST_MDRV;
				ST_MDRV:  state_q <= ST_GDRV;
				ST_GDRV:  state_q <= ST_TSEG;
				ST_TSEG:  state_q <= ST_MTANH;
				ST_MTANH: state_q <= ST_GTANH;
				ST_GTANH: state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_MBL;
				ST_MBL:   state_q <= ST_GMIX;
				ST_GMIX:  state_q <= ST_MTRIM;
				ST_MTRIM: state_q <= ST_GOUT;
				ST_GOUT:  state_q <= ST_FIN;
				ST_FIN: begin
					// wait for the output register to free up
					if (!result_valid || result_ready) begin
						result_valid <= 1'b1;
						if (adv_q)
							phase_q <= phase_q + PHASE_W'(cfg_q.phase_step);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q   <= sample_in;
				ch_q  <= channel;
				res_q <= '0;
			end
			ST_S2:   z2_q <= p_q[32:16];
			ST_S3:   t_q  <= 17'd42047 - p_q[32:16];
			ST_S5:   t_q  <= 17'd102944 - p_q[32:16];
			ST_S7:   sine_q <= quad[1] ? -16'(signed'({1'b0, s_clip}))
				: 16'(signed'({1'b0, s_clip}));
			ST_BY: begin
				bx_q <= p_q;
				y_q  <= sat32(y_sum);
			end
			ST_BS2: begin
				if (!fsel_q)
					low_q <= y_q;
			end
			ST_RECT: begin
				// magnitude of the sub output, most negative value clamps
				if (!y_q[FILT_W-1])
					rect_q <= y_q[FILT_W-2:0];
				else if (y_q == {1'b1, {(FILT_W-1){1'b0}}})
					rect_q <= '1;
				else
					rect_q <= (FILT_W-1)'(-y_q);
			end
			ST_GSYN:  acc_q <= ACC_W'((p_q + HALF15) >>> 15);
			ST_GSUM:  acc_q <= ACC_W'(low_q) + ACC_W'((p_q + HALF15) >>> 15);
			ST_GDRV:  acc_q <= ACC_W'((p_q + HALF13) >>> 13);
			ST_TSEG: begin
				neg_q  <= acc_q[ACC_W-1];
				big_q  <= |mag[ACC_W-1:SEG_SHIFT+5];
				base_q <= tab_lo;
				d_q    <= 12'(tab_hi - tab_lo);
				frac_q <= mag[SEG_SHIFT-1:0];
			end
			ST_GTANH: acc_q <= neg_q ? -forged : forged;
			ST_DIFF:  acc_q <= acc_q - ACC_W'(x_q);
			ST_GMIX:  acc_q <= ACC_W'(x_q) + ACC_W'((p_q + HALF15) >>> 15);
			ST_GOUT:  res_q <= out_sat;
			ST_FIN: begin
				if (!result_valid || result_ready) begin
					sample_out  <= res_q;
					channel_out <= ch_q;
				end
			end
			default: ;
		endcase
	end

endmodule
